/* sv/assert_macros.svh */
// Assertion macros for the range paint table RTL.
// Needs nothing else; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/fwrpt_pkg.sv */
// Shared types and constants for the first-write range paint table.
// Used by the sequencer, the owner memory and the top level; depends on nothing.
package fwrpt_pkg;

    localparam int FIELD_W = 11;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_PAINT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef logic [FIELD_W-1:0] field_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PAINT,
        ST_READ,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_en_t;

endpackage

/* sv/fwrpt_mem.sv */
// Owner memory: one write port and one read port with registered read data.
// Depends on fwrpt_pkg for the field type and the enable struct.
module fwrpt_mem
    import fwrpt_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int AW         = 10
)
(
    input  logic          clk,
    input  mem_en_t       mem_en,
    input  logic [AW-1:0] wr_addr,
    input  field_t        wr_data,
    input  logic [AW-1:0] rd_addr,
    output field_t        rd_data
);

    field_t mem_array [TABLE_SIZE];
    field_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_en.wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en.rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/fwrpt_seq.sv */
// Sequencer: walks one table position per cycle with a shared incrementer and compare.
// Depends on fwrpt_pkg and assert_macros.svh; drives the owner memory ports.
`include "assert_macros.svh"

module fwrpt_seq
    import fwrpt_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int AW         = 10
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] op,
    input  logic            paint_ok,
    input  logic            read_ok,
    input  logic [AW-1:0]   first_addr,
    input  logic [AW-1:0]   last_addr,
    input  logic [AW-1:0]   read_addr,
    input  field_t          owner_value,
    input  logic            out_free,
    output logic            resp_load,
    output logic            resp_zero,
    output mem_en_t         mem_en,
    output logic [AW-1:0]   wr_addr,
    output field_t          wr_data,
    output logic [AW-1:0]   rd_addr,
    input  field_t          rd_data
);

    localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_SIZE - 1);

    state_t        state_reg, state_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] last_reg, last_next;
    field_t        value_reg, value_next;
    logic          zero_reg, zero_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;

    logic [AW-1:0] limit;
    logic          walk_done;

    // The one compare that ends both the clearing sweep and the paint walk.
    assign limit     = (state_reg == ST_CLEAR) ? LAST_ENTRY : last_reg;
    assign walk_done = (ptr_reg == limit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        OP_PAINT: state_next = paint_ok ? ST_PAINT : ST_IDLE;
                        OP_READ:  state_next = read_ok ? ST_READ : ST_RESP;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: state_next = walk_done ? ST_IDLE : ST_CLEAR;
            ST_PAINT: state_next = walk_done ? ST_IDLE : ST_PAINT;
            ST_READ:  state_next = ST_RESP;
            ST_RESP:  state_next = out_free ? ST_IDLE : ST_RESP;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ptr_next       = ptr_reg;
        last_next      = last_reg;
        value_next     = value_reg;
        zero_next      = zero_reg;
        chk_valid_next = (state_reg == ST_PAINT);
        chk_addr_next  = ptr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next  = last_addr;
                    value_next = owner_value;
                    zero_next  = !read_ok;
                    case (op)
                        OP_PAINT: ptr_next = first_addr;
                        OP_READ:  ptr_next = read_addr;
                        default:  ptr_next = '0;
                    endcase
                end
            end
            ST_CLEAR: ptr_next = ptr_reg + 1'b1;
            ST_PAINT: ptr_next = ptr_reg + 1'b1;
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        mem_en.rd_en  = (state_reg == ST_PAINT) || (state_reg == ST_READ);
        rd_addr       = ptr_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_en.wr_en = 1'b1;
            wr_addr      = ptr_reg;
            wr_data      = '0;
        end
        else
        begin
            mem_en.wr_en = chk_valid_reg && (rd_data == '0);
            wr_addr      = chk_addr_reg;
            wr_data      = value_reg;
        end
        resp_load = (state_reg == ST_RESP) && out_free;
        resp_zero = zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        value_reg    <= value_next;
        zero_reg     <= zero_next;
        chk_addr_reg <= chk_addr_next;
    end

    `ASSERT_IMPLY(a_rmw_addr_apart, clk, rst_n, mem_en.wr_en && mem_en.rd_en, wr_addr != rd_addr)
    `ASSERT_IMPLY(a_paint_in_range, clk, rst_n, state_reg == ST_PAINT, ptr_reg <= last_reg)
    `ASSERT_NEXT(a_paint_drain, clk, rst_n, state_reg == ST_PAINT && walk_done, state_reg == ST_IDLE && chk_valid_reg)
    `ASSERT_IMPLY(a_check_after_paint, clk, rst_n, chk_valid_reg, $past(state_reg) == ST_PAINT)

endmodule

/* sv/first_write_range_paint_table.sv */
// A paint holds in_ready low while it walks its clipped positions, a clear while it sweeps
// the table. A read passes through ST_READ, where the memory read is made, and ST_RESP,
// which loads the item once the output is free; a read outside the table skips ST_READ.
// Throughput is one position per cycle, set by the single read and write port of the memory.
// Reset (rst_n, asynchronous, active low) starts a clearing pass of the whole owner memory,
// during which no item is accepted.
module first_write_range_paint_table
    import fwrpt_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] op,
    input  field_t          lo,
    input  field_t          hi,
    input  field_t          owner_value,
    output logic            out_valid,
    input  logic            out_ready,
    output field_t          read_value
);

    localparam int AW   = $clog2(TABLE_SIZE);
    localparam int PB   = $clog2(TABLE_SIZE + 1);
    localparam int PW   = (PB > FIELD_W) ? PB : FIELD_W;
    localparam logic [PW-1:0] TS_P  = PW'(TABLE_SIZE);
    localparam logic [PW-1:0] ONE_P = PW'(1);

    logic [PW-1:0] lo_p, hi_p, first_p, last_p;
    logic          paint_ok, read_ok;
    logic [AW-1:0] first_addr, last_addr, read_addr;
    logic          out_free, resp_load, resp_zero;
    mem_en_t       mem_en;
    logic [AW-1:0] wr_addr, rd_addr;
    field_t        wr_data, rd_data;
    logic          out_valid_reg, out_valid_next;
    field_t        read_value_reg, read_value_next;

    // Positions run from one to TABLE_SIZE; the range is clipped to that span.
    assign lo_p       = PW'(lo);
    assign hi_p       = PW'(hi);
    assign first_p    = (lo_p == '0) ? ONE_P : lo_p;
    assign last_p     = (hi_p > TS_P) ? TS_P : hi_p;
    assign paint_ok   = (first_p <= last_p);
    assign read_ok    = (lo_p != '0) && (lo_p <= TS_P);
    assign first_addr = AW'(first_p - ONE_P);
    assign last_addr  = AW'(last_p - ONE_P);
    assign read_addr  = AW'(lo_p - ONE_P);

    assign out_free = !out_valid_reg || out_ready;

    fwrpt_seq #(
        .TABLE_SIZE (TABLE_SIZE),
        .AW         (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .paint_ok    (paint_ok),
        .read_ok     (read_ok),
        .first_addr  (first_addr),
        .last_addr   (last_addr),
        .read_addr   (read_addr),
        .owner_value (owner_value),
        .out_free    (out_free),
        .resp_load   (resp_load),
        .resp_zero   (resp_zero),
        .mem_en      (mem_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    fwrpt_mem #(
        .TABLE_SIZE (TABLE_SIZE),
        .AW         (AW)
    ) u_mem (
        .clk     (clk),
        .mem_en  (mem_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        read_value_next = read_value_reg;
        if (resp_load)
        begin
            out_valid_next  = 1'b1;
            read_value_next = resp_zero ? '0 : rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

endmodule
